// ----- src/prim_min_spanning_tree_macros.svh -----
// prim_min_spanning_tree_macros.svh: assertion shorthands for the spanning tree checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PRIM_MIN_SPANNING_TREE_MACROS_SVH
`define PRIM_MIN_SPANNING_TREE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PMST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PMST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pmst_pkg.sv -----
// pmst_pkg: state encoding, opcodes and reset constants for the spanning tree block.
// No dependencies.
`timescale 1ns / 1ps

package pmst_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PAIR,
    S_PAIR_WAIT,
    S_PAIR_END,
    S_SWEEP,
    S_SWEEP_WAIT,
    S_ROUND_END
  } state_t;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SOLVE = 2'd2;

  localparam logic [5:0] NODE_COUNT_RST = 6'd32;

endpackage

// ----- src/prim_min_spanning_tree.sv -----
// prim_min_spanning_tree: Prim spanning tree over a weight matrix in block RAM; uses pmst_pkg.
// Add edge: back to back. Clear: writes all 2**(2*clog2(MAX_NODES)) matrix words (1024 by default).
// Solve: the first edge comes from one matrix read a cycle over the upper triangle, each
//   further edge from one sweep of the nearest-vertex RAM.
// Results are registered, shown for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) starts the matrix clear; busy stays high until it ends.
`timescale 1ns / 1ps

module prim_min_spanning_tree #(
  parameter int MAX_NODES   = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_op,
  input  logic [5:0]             in_node_a,
  input  logic [5:0]             in_node_b,
  input  logic [WEIGHT_BITS-1:0] in_weight,
  output logic                   out_valid,
  output logic [5:0]             out_from_node,
  output logic [5:0]             out_to_node,
  output logic [WEIGHT_BITS-1:0] out_edge_weight,
  output logic                   out_last,
  output logic                   out_not_connected,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [5:0]             cfg_node_count
);
  import pmst_pkg::*;

  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int NODE_W    = $clog2(MAX_NODES + 1);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int WM_DEPTH  = 1 << ADDR_W;
  localparam int NTV_DEPTH = 1 << IDX_W;
  localparam int ENT_W     = NODE_W + WEIGHT_BITS;
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

  // Only the upper triangle is stored: cell (p,q) lives at row min(p,q), column max(p,q).
  function automatic logic [ADDR_W-1:0] tri_addr(logic [NODE_W-1:0] p, logic [NODE_W-1:0] q);
    logic [NODE_W-1:0] lo_m1;
    logic [NODE_W-1:0] hi_m1;
    lo_m1 = ((p < q) ? p : q) - NODE_W'(1);
    hi_m1 = ((p < q) ? q : p) - NODE_W'(1);
    return {lo_m1[IDX_W-1:0], hi_m1[IDX_W-1:0]};
  endfunction

  function automatic logic [IDX_W-1:0] node_idx(logic [NODE_W-1:0] p);
    logic [NODE_W-1:0] p_m1;
    p_m1 = p - NODE_W'(1);
    return p_m1[IDX_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [5:0]             node_count_r;
  logic [NODE_W-1:0]      n_r, n_nxt;
  logic [NODE_W-1:0]      pi_r, pi_nxt, pj_r, pj_nxt, sj_r, sj_nxt;
  logic [NODE_W-1:0]      rnd_r, rnd_nxt;
  logic [NODE_W-1:0]      u_r, u_nxt, v_r, v_nxt, x_r, x_nxt;
  logic [NODE_W-1:0]      best_x_r, best_x_nxt, best_from_r, best_from_nxt;
  logic [WEIGHT_BITS-1:0] best_w_r, best_w_nxt;
  logic                   first_r, first_nxt;
  logic                   p_vld_r, p_vld_nxt;
  logic [NODE_W-1:0]      p_i_r, p_i_nxt, p_j_r, p_j_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [5:0]             out_from_r, out_from_nxt, out_to_r, out_to_nxt;
  logic [WEIGHT_BITS-1:0] out_w_r, out_w_nxt;
  logic                   out_last_r, out_last_nxt, out_nc_r, out_nc_nxt;

  // Weight matrix RAM: one write port, two registered read ports.
  logic [WEIGHT_BITS-1:0] wm_mem [WM_DEPTH];
  logic                   wm_we;
  logic [ADDR_W-1:0]      wm_waddr, wm_raddr_a, wm_raddr_b;
  logic [WEIGHT_BITS-1:0] wm_wdata, wm_rd_a_r, wm_rd_b_r;

  // Nearest tree vertex RAM: entry holds {nearest vertex, weight to it}; vertex 0 means in tree.
  logic [ENT_W-1:0]       ntv_mem [NTV_DEPTH];
  logic                   ntv_we;
  logic [IDX_W-1:0]       ntv_waddr, ntv_raddr;
  logic [ENT_W-1:0]       ntv_wdata, ntv_rd_r;
  logic [NODE_W-1:0]      ntv_rd_nj;
  logic [WEIGHT_BITS-1:0] ntv_rd_w;

  logic [NODE_W-1:0]      n_clamp, a_n, b_n;
  logic                   a_ok, b_ok;
  logic [NODE_W-1:0]      sw_nj;
  logic [WEIGHT_BITS-1:0] sw_w;
  logic                   pair_last, sweep_last, rnd_last;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_from_node     = out_from_r;
  assign out_to_node       = out_to_r;
  assign out_edge_weight   = out_w_r;
  assign out_last          = out_last_r;
  assign out_not_connected = out_nc_r;

  assign ntv_rd_nj = ntv_rd_r[ENT_W-1:WEIGHT_BITS];
  assign ntv_rd_w  = ntv_rd_r[WEIGHT_BITS-1:0];

  assign a_ok = (in_node_a != 6'd0) && (int'(in_node_a) <= MAX_NODES);
  assign b_ok = (in_node_b != 6'd0) && (int'(in_node_b) <= MAX_NODES);
  assign a_n  = NODE_W'(in_node_a);
  assign b_n  = NODE_W'(in_node_b);

  assign pair_last  = (pi_r == n_r - NODE_W'(1)) && (pj_r == n_r);
  assign sweep_last = (sj_r == n_r);
  assign rnd_last   = ((rnd_r + NODE_W'(2)) == n_r);

  always_comb begin
    if (node_count_r < 6'd2) begin
      n_clamp = NODE_W'(2);
    end else if (int'(node_count_r) > MAX_NODES) begin
      n_clamp = NODE_W'(MAX_NODES);
    end else begin
      n_clamp = NODE_W'(node_count_r);
    end
  end

  // Candidate entry for the vertex in the sweep stage.
  always_comb begin
    if (first_r) begin
      if (p_j_r == u_r || p_j_r == v_r) begin
        sw_nj = '0;
        sw_w  = wm_rd_a_r;
      end else if (wm_rd_a_r < wm_rd_b_r) begin
        sw_nj = u_r;
        sw_w  = wm_rd_a_r;
      end else begin
        sw_nj = v_r;
        sw_w  = wm_rd_b_r;
      end
    end else begin
      if (p_j_r == x_r) begin
        sw_nj = '0;
        sw_w  = ntv_rd_w;
      end else if (ntv_rd_nj != '0 && wm_rd_a_r < ntv_rd_w) begin
        sw_nj = x_r;
        sw_w  = wm_rd_a_r;
      end else begin
        sw_nj = ntv_rd_nj;
        sw_w  = ntv_rd_w;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    n_nxt         = n_r;
    pi_nxt        = pi_r;
    pj_nxt        = pj_r;
    sj_nxt        = sj_r;
    rnd_nxt       = rnd_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    x_nxt         = x_r;
    best_x_nxt    = best_x_r;
    best_from_nxt = best_from_r;
    best_w_nxt    = best_w_r;
    first_nxt     = first_r;
    p_vld_nxt     = 1'b0;
    p_i_nxt       = pi_r;
    p_j_nxt       = pj_r;
    out_valid_nxt = 1'b0;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    out_w_nxt     = out_w_r;
    out_last_nxt  = out_last_r;
    out_nc_nxt    = out_nc_r;
    wm_we         = 1'b0;
    wm_waddr      = tri_addr(a_n, b_n);
    wm_wdata      = in_weight;
    wm_raddr_a    = tri_addr(pi_r, pj_r);
    wm_raddr_b    = tri_addr(sj_r, v_r);
    ntv_we        = 1'b0;
    ntv_waddr     = node_idx(p_j_r);
    ntv_wdata     = {sw_nj, sw_w};
    ntv_raddr     = node_idx(sj_r);

    unique case (state_r)
      S_CLEAR: begin
        wm_we        = 1'b1;
        wm_waddr     = clr_addr_r;
        wm_wdata     = NO_EDGE;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (&clr_addr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (in_op)
            OP_ADD: begin
              wm_we = a_ok && b_ok;
            end
            OP_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            OP_SOLVE: begin
              n_nxt      = n_clamp;
              pi_nxt     = NODE_W'(1);
              pj_nxt     = NODE_W'(2);
              best_w_nxt = NO_EDGE;
              state_nxt  = S_PAIR;
            end
            default: begin
              // unused opcode: drop the transaction
            end
          endcase
        end
      end
      S_PAIR: begin
        p_vld_nxt = 1'b1;
        p_i_nxt   = pi_r;
        p_j_nxt   = pj_r;
        if (pair_last) begin
          state_nxt = S_PAIR_WAIT;
        end else if (pj_r == n_r) begin
          pi_nxt = pi_r + NODE_W'(1);
          pj_nxt = pi_r + NODE_W'(2);
        end else begin
          pj_nxt = pj_r + NODE_W'(1);
        end
      end
      S_PAIR_WAIT: begin
        state_nxt = S_PAIR_END;
      end
      S_PAIR_END: begin
        out_valid_nxt = 1'b1;
        if (best_w_r == NO_EDGE) begin
          out_from_nxt = '0;
          out_to_nxt   = '0;
          out_w_nxt    = '0;
          out_last_nxt = 1'b1;
          out_nc_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          out_from_nxt = 6'(u_r);
          out_to_nxt   = 6'(v_r);
          out_w_nxt    = best_w_r;
          out_last_nxt = (n_r == NODE_W'(2));
          out_nc_nxt   = 1'b0;
          if (n_r == NODE_W'(2)) begin
            state_nxt = S_IDLE;
          end else begin
            first_nxt  = 1'b1;
            sj_nxt     = NODE_W'(1);
            rnd_nxt    = NODE_W'(1);
            best_w_nxt = NO_EDGE;
            best_x_nxt = '0;
            state_nxt  = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        wm_raddr_a = tri_addr(sj_r, first_r ? u_r : x_r);
        p_vld_nxt  = 1'b1;
        p_j_nxt    = sj_r;
        sj_nxt     = sj_r + NODE_W'(1);
        if (sweep_last) begin
          state_nxt = S_SWEEP_WAIT;
        end
      end
      S_SWEEP_WAIT: begin
        state_nxt = S_ROUND_END;
      end
      S_ROUND_END: begin
        out_valid_nxt = 1'b1;
        if (best_x_r == '0) begin
          out_from_nxt = '0;
          out_to_nxt   = '0;
          out_w_nxt    = '0;
          out_last_nxt = 1'b1;
          out_nc_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          out_from_nxt = 6'(best_from_r);
          out_to_nxt   = 6'(best_x_r);
          out_w_nxt    = best_w_r;
          out_last_nxt = rnd_last;
          out_nc_nxt   = 1'b0;
          if (rnd_last) begin
            state_nxt = S_IDLE;
          end else begin
            rnd_nxt    = rnd_r + NODE_W'(1);
            x_nxt      = best_x_r;
            first_nxt  = 1'b0;
            sj_nxt     = NODE_W'(1);
            best_w_nxt = NO_EDGE;
            best_x_nxt = '0;
            state_nxt  = S_SWEEP;
          end
        end
      end
    endcase

    // Read data stage: first strict minimum wins, so ties keep the lower index.
    if (p_vld_r && (state_r == S_PAIR || state_r == S_PAIR_WAIT)) begin
      if (wm_rd_a_r < best_w_r) begin
        best_w_nxt = wm_rd_a_r;
        u_nxt      = p_i_r;
        v_nxt      = p_j_r;
      end
    end
    if (p_vld_r && (state_r == S_SWEEP || state_r == S_SWEEP_WAIT)) begin
      ntv_we = 1'b1;
      if (sw_nj != '0 && sw_w < best_w_r) begin
        best_w_nxt    = sw_w;
        best_x_nxt    = p_j_r;
        best_from_nxt = sw_nj;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      node_count_r <= NODE_COUNT_RST;
      p_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    pi_r        <= pi_nxt;
    pj_r        <= pj_nxt;
    sj_r        <= sj_nxt;
    rnd_r       <= rnd_nxt;
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    x_r         <= x_nxt;
    best_x_r    <= best_x_nxt;
    best_from_r <= best_from_nxt;
    best_w_r    <= best_w_nxt;
    first_r     <= first_nxt;
    p_i_r       <= p_i_nxt;
    p_j_r       <= p_j_nxt;
    out_from_r  <= out_from_nxt;
    out_to_r    <= out_to_nxt;
    out_w_r     <= out_w_nxt;
    out_last_r  <= out_last_nxt;
    out_nc_r    <= out_nc_nxt;
  end

  always_ff @(posedge clk) begin
    if (wm_we) begin
      wm_mem[wm_waddr] <= wm_wdata;
    end
    wm_rd_a_r <= wm_mem[wm_raddr_a];
    wm_rd_b_r <= wm_mem[wm_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (ntv_we) begin
      ntv_mem[ntv_waddr] <= ntv_wdata;
    end
    ntv_rd_r <= ntv_mem[ntv_raddr];
  end

endmodule

// ----- src/pmst_checker.sv -----
// pmst_checker: port-level checks on the spanning tree block, bound to its top level.
// Depends on pmst_pkg and prim_min_spanning_tree_macros.svh.
`timescale 1ns / 1ps
`include "prim_min_spanning_tree_macros.svh"

module pmst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic [5:0] out_from_node,
  input logic [5:0] out_to_node,
  input logic       out_last,
  input logic       out_not_connected
);
  import pmst_pkg::*;

  // a result that is not the last one leaves the block still working on the solve
  `PMST_ASSERT_SAME(a_mid_result_busy, out_valid && !out_last, busy, "mid-solve result while idle")
  `PMST_ASSERT_SAME(a_err_shape, out_valid && out_not_connected, out_last && out_from_node == 6'd0 && out_to_node == 6'd0, "malformed not-connected result")
  `PMST_ASSERT_NEXT(a_last_ends, out_valid && out_last, !out_valid, "result after the last one")
  `PMST_ASSERT_NEXT(a_solve_busy, start && !busy && in_op == OP_SOLVE, busy, "solve transaction did not raise busy")
  `PMST_ASSERT_NEXT(a_add_idle, start && !busy && in_op == OP_ADD, !busy, "edge add transaction stalled input")

endmodule

bind prim_min_spanning_tree pmst_checker u_pmst_checker (.*);
